// File: sv/ohsi_pkg.sv
`timescale 1ns / 1ps

package ohsi_pkg;

  // Field widths
  localparam int KEY_W    = 64;
  localparam int CNT_W    = 8;
  localparam int STATUS_W = 2;

  // Default slot count (power of two, 4 .. 65536)
  localparam int TABLE_SLOTS_DEF = 256;

  // Hash taps: home slot from key >> 4, step from key >> 8
  localparam int HOME_SHIFT = 4;
  localparam int STEP_SHIFT = 8;

  // Largest count the 8-bit counter can hold
  localparam int LIMIT_MAX = 255;

  localparam logic [CNT_W-1:0] LIMIT_RESET = 8'd224;

  // Result codes
  typedef enum logic [STATUS_W-1:0] {
    STS_NEW  = 2'd0,
    STS_DUP  = 2'd1,
    STS_FULL = 2'd2,
    STS_ZERO = 2'd3
  } status_e;

  // Controller -> datapath
  typedef struct packed {
    logic    clr_wr;   // write zero to the clear pointer slot
    logic    load;     // take the new key, read its home slot
    logic    advance;  // move on by the current step, read next slot
    logic    place;    // write the carried key, pick up the slot's old key
    logic    finish;   // post a result
    logic    cnt_inc;  // one more key stored
    status_e res;      // result code with finish
  } ohsi_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic in_zero;    // incoming key is zero
    logic eq;         // slot holds the carried key
    logic lt;         // slot holds a smaller key (or is empty)
    logic here_zero;  // slot is empty
    logic full;       // count at or above the effective limit
    logic clr_last;   // clear pointer at the last slot
  } ohsi_sts_t;

endpackage

// File: sv/ohsi_ram.sv
`timescale 1ns / 1ps

module ohsi_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/ohsi_ctrl.sv
`timescale 1ns / 1ps

module ohsi_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  ohsi_pkg::ohsi_sts_t sts_i,
  output ohsi_pkg::ohsi_cmd_t cmd_o
);

  import ohsi_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT
  } state_e;

  state_e    state_q, state_d;
  ohsi_cmd_t cmd;

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd     = '0;
    cmd.res = STS_NEW;
    case (state_q)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (sts_i.in_zero) begin
            cmd.finish = 1'b1;
            cmd.res    = STS_ZERO;
          end else begin
            cmd.load = 1'b1;
            state_d  = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        // look for the key itself or the first smaller slot
        if (sts_i.eq) begin
          cmd.finish = 1'b1;
          cmd.res    = STS_DUP;
          state_d    = ST_IDLE;
        end else if (sts_i.lt && sts_i.full) begin
          cmd.finish = 1'b1;
          cmd.res    = STS_FULL;
          state_d    = ST_IDLE;
        end else if (sts_i.lt) begin
          cmd.place = 1'b1;
          if (sts_i.here_zero) begin
            cmd.finish  = 1'b1;
            cmd.cnt_inc = 1'b1;
            state_d     = ST_IDLE;
          end else begin
            state_d = ST_SHIFT;
          end
        end else begin
          cmd.advance = 1'b1;
        end
      end
      ST_SHIFT: begin
        // carry a displaced key on until an empty slot takes it
        if (sts_i.lt) begin
          cmd.place = 1'b1;
          if (sts_i.here_zero) begin
            cmd.finish  = 1'b1;
            cmd.cnt_inc = 1'b1;
            state_d     = ST_IDLE;
          end
        end else begin
          cmd.advance = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy  = (state_q != ST_IDLE);
  assign cmd_o = cmd;

  // No item taken or finished while the table is being cleared
  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !cmd.load && !cmd.finish)
    else $error("item activity during clear pass");

  // A probe step either moves on or writes, never both
  a_one_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.advance && cmd.place))
    else $error("advance and place together");

endmodule

// File: sv/ohsi_dpath.sv
`timescale 1ns / 1ps

module ohsi_dpath #(
  parameter int TABLE_SLOTS = ohsi_pkg::TABLE_SLOTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ohsi_pkg::ohsi_cmd_t           cmd_i,
  output ohsi_pkg::ohsi_sts_t           sts_o,
  input  logic [ohsi_pkg::KEY_W-1:0]    key_i,
  input  logic                          cfg_valid_i,
  input  logic [ohsi_pkg::CNT_W-1:0]    cfg_data_i,
  output logic                          done_o,
  output logic [ohsi_pkg::STATUS_W-1:0] status_o,
  output logic [ohsi_pkg::CNT_W-1:0]    stored_count_o
);

  import ohsi_pkg::*;

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  // Keep at least one slot empty
  localparam int CAP_I  = (TABLE_SLOTS - 1 > LIMIT_MAX) ? LIMIT_MAX : TABLE_SLOTS - 1;
  localparam logic [CNT_W-1:0]  CNT_CAP = CNT_W'(CAP_I);
  localparam logic [SLOT_W-1:0] ODD_BIT = {{(SLOT_W-1){1'b0}}, 1'b1};

  function automatic logic [SLOT_W-1:0] step_of(input logic [KEY_W-1:0] k);
    step_of = k[STEP_SHIFT +: SLOT_W] | ODD_BIT;
  endfunction

  logic [KEY_W-1:0]  cur_q;
  logic [SLOT_W-1:0] pos_q, step_q, clr_q;
  logic [CNT_W-1:0]  count_q, limit_q;
  logic              done_q;
  status_e           status_q;

  logic [KEY_W-1:0]  here;
  logic [SLOT_W-1:0] rd_addr, wr_addr;
  logic [KEY_W-1:0]  wr_data;
  logic              wr_en;

  // Read address: home slot on load, else next slot of the active step
  always_comb begin
    if (cmd_i.load) begin
      rd_addr = key_i[HOME_SHIFT +: SLOT_W];
    end else if (cmd_i.place) begin
      rd_addr = pos_q + step_of(here);
    end else begin
      rd_addr = pos_q + step_q;
    end
  end

  // Write port: clear sweep or key placement
  assign wr_en   = cmd_i.clr_wr | cmd_i.place;
  assign wr_addr = cmd_i.clr_wr ? clr_q : pos_q;
  assign wr_data = cmd_i.clr_wr ? '0 : cur_q;

  ohsi_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (here)
  );

  // Probe registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_q  <= key_i;
      step_q <= step_of(key_i);
    end else if (cmd_i.place) begin
      cur_q  <= here;
      step_q <= step_of(here);
    end
    if (cmd_i.load || cmd_i.place || cmd_i.advance) begin
      pos_q <= rd_addr;
    end
    if (cmd_i.finish) begin
      status_q <= cmd_i.res;
    end
  end

  // Control state: clear pointer, count, limit, result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      count_q <= '0;
      limit_q <= LIMIT_RESET;
      done_q  <= 1'b0;
    end else begin
      if (cmd_i.clr_wr) begin
        clr_q <= clr_q + ODD_BIT;
      end
      if (cmd_i.cnt_inc) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
      done_q <= cmd_i.finish;
    end
  end

  // Status to the controller
  assign sts_o.in_zero   = (key_i == '0);
  assign sts_o.eq        = (here == cur_q);
  assign sts_o.lt        = (here < cur_q);
  assign sts_o.here_zero = (here == '0);
  assign sts_o.full      = (count_q >= limit_q) || (count_q >= CNT_CAP);
  assign sts_o.clr_last  = (clr_q == {SLOT_W{1'b1}});

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign stored_count_o = count_q;

  // Placement never writes the slot being read in the same cycle
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.place |-> rd_addr != pos_q)
    else $error("placement write hits read address");

  // Count never passes the cap that keeps an empty slot
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_CAP)
    else $error("key count above cap");

endmodule

// File: sv/ordered_hash_set_insert_top.sv
`timescale 1ns / 1ps

// Ordered hash set, insert only, with double hashing over TABLE_SLOTS slots.
// Input: pulse start with key_i while busy is low; the key is taken at
// that edge. busy stays high while the insert walks the table.
// Output: done_o is high for exactly one cycle with status_o
// (0 new, 1 present, 2 full, 3 zero key) and stored_count_o; the receiver
// cannot stall it, so it must take the result in that cycle.
// A zero key answers in the cycle after start without raising busy.
// Otherwise the insert reads one slot per cycle: first the probes on the
// key's own chain, then further probes moving displaced keys, done_o
// coming the cycle after the last probe. The slot memory's single
// registered read port sets this one-probe-per-cycle pace.
// Configuration: cfg_data_i is the entry limit, written when cfg_valid_i
// is high (cfg_ready_o is always high); write it only while idle.
// Reset: after reset a clearing pass zeroes every slot of the table,
// with busy high throughout; the limit resets to 224.
// TABLE_SLOTS must be a power of two.

module ordered_hash_set_insert_top #(
  parameter int TABLE_SLOTS = ohsi_pkg::TABLE_SLOTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [ohsi_pkg::KEY_W-1:0]    key_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ohsi_pkg::CNT_W-1:0]    cfg_data_i,
  output logic                          done_o,
  output logic [ohsi_pkg::STATUS_W-1:0] status_o,
  output logic [ohsi_pkg::CNT_W-1:0]    stored_count_o
);

  import ohsi_pkg::*;

  ohsi_cmd_t cmd;
  ohsi_sts_t sts;

  // Limit register takes every write
  assign cfg_ready_o = 1'b1;

  ohsi_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  ohsi_dpath #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .key_i          (key_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .stored_count_o (stored_count_o)
  );

endmodule

// File: tb/sv/ordered_hash_set_insert_top_tb.sv
`timescale 1ns / 1ps

module ordered_hash_set_insert_top_tb;
  import ohsi_pkg::*;

  localparam int SLOTS       = TABLE_SLOTS_DEF;
  localparam int MASK        = SLOTS - 1;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int PHASE_ITEMS = 290;

  typedef struct {
    status_e          status;
    logic [CNT_W-1:0] count;
  } outcome_t;

  // Set contents and outcome queue, updated on every accepted transfer
  class ordered_set_tracker;
    logic [KEY_W-1:0] slots [SLOTS];
    logic [CNT_W-1:0] key_count;
    logic [CNT_W-1:0] limit;
    outcome_t         pending_outcomes [$];
    logic [KEY_W-1:0] held_keys [$];
    int               errors;
    int               checked;
    int               status_seen [4];

    function new();
      foreach (slots[i]) slots[i] = '0;
      key_count = '0;
      limit     = LIMIT_RESET;
      errors    = 0;
      checked   = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void set_limit(logic [CNT_W-1:0] v);
      limit = v;
    endfunction

    // Walk the key's chain, then place it and push displaced keys along
    function void predict_insert(logic [KEY_W-1:0] k);
      logic [KEY_W-1:0] carry, cur;
      int unsigned      pos, step, n, lim;
      bit               found, placed;
      outcome_t         o;
      found = 1'b0;
      lim   = (int'(limit) > MASK) ? MASK : int'(limit);
      if (k == '0) begin
        o.status = STS_ZERO;
      end else begin
        pos  = int'((k >> HOME_SHIFT) & 64'(MASK));
        step = int'(((k >> STEP_SHIFT) | 64'd1) & 64'(MASK));
        for (n = 0; n < SLOTS; n++) begin
          if (slots[pos] == k) begin
            found = 1'b1;
            break;
          end
          if (slots[pos] < k) break;
          pos = (pos + step) & MASK;
        end
        if (found) begin
          o.status = STS_DUP;
        end else if (int'(key_count) >= lim || n >= SLOTS) begin
          o.status = STS_FULL;
        end else begin
          carry      = slots[pos];
          slots[pos] = k;
          while (carry != '0) begin
            cur    = carry;
            placed = 1'b0;
            step   = int'(((cur >> STEP_SHIFT) | 64'd1) & 64'(MASK));
            pos    = (pos + step) & MASK;
            for (n = 0; n < SLOTS; n++) begin
              if (slots[pos] < cur) begin
                carry      = slots[pos];
                slots[pos] = cur;
                placed     = 1'b1;
                break;
              end
              pos = (pos + step) & MASK;
            end
            // a key that finds no place is dropped
            if (!placed) carry = '0;
          end
          key_count = key_count + 1'b1;
          held_keys.push_back(k);
          o.status = STS_NEW;
        end
      end
      o.count = key_count;
      pending_outcomes.push_back(o);
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [CNT_W-1:0] cnt);
      outcome_t o;
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected result: status %0d count %0d", $time, st, cnt);
        errors++;
        return;
      end
      o = pending_outcomes.pop_front();
      if (st !== o.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d", $time, o.status, st);
        errors++;
      end
      if (cnt !== o.count) begin
        $display("%0t: stored_count mismatch: expected %0d actual %0d",
                 $time, o.count, cnt);
        errors++;
      end
      checked++;
      status_seen[o.status]++;
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [KEY_W-1:0]    key_i;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CNT_W-1:0]    cfg_data_i;
  logic                done_o;
  logic [STATUS_W-1:0] status_o;
  logic [CNT_W-1:0]    stored_count_o;

  ordered_set_tracker sb = new();
  int                 keys_taken   = 0;
  int                 limit_writes = 0;
  int                 cycles       = 0;
  logic [7:0]         cluster_home [4];

  ordered_hash_set_insert_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .key_i          (key_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .stored_count_o (stored_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Timeout
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("status: fail");
    $finish;
  end

  // Monitor: results, key transfers and limit writes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_result(status_o, stored_count_o);
      if (start && !busy) begin
        sb.predict_insert(key_i);
        keys_taken++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        sb.set_limit(cfg_data_i);
        limit_writes++;
      end
    end
  end

  task automatic send_key(input logic [KEY_W-1:0] k);
    start <= 1'b1;
    key_i <= k;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic pause(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Let every outstanding insert finish; the first edge lets the monitor
  // note a key taken at the edge this task was entered on
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_outcomes.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [CNT_W-1:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly fresh and clustered keys, with repeats, zeros and near-max keys
  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    int               sel;
    sel = $urandom_range(0, 99);
    k   = {$urandom, $urandom};
    if (sel < 35) begin
      // fully random
    end else if (sel < 50) begin
      k[11:4] = cluster_home[$urandom_range(0, 3)];
    end else if (sel < 60) begin
      // same home and step, differing only in the low nibble
      k = {40'h00_0000_0000, 12'hA53, k[3:0], 8'h00} >> 8;
      k = {k[63:4], 4'(sel)};
    end else if (sel < 88) begin
      if (sb.held_keys.size() != 0)
        k = sb.held_keys[$urandom_range(0, sb.held_keys.size() - 1)];
    end else if (sel < 94) begin
      k = '0;
    end else begin
      k = ~{56'h0, 8'($urandom_range(0, 40))};
    end
    return k;
  endfunction

  task automatic run_items(input int n, input int gap_max);
    int burst;
    int gap;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 16);
        gap   = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        if (gap > 0) pause(gap);
      end
      send_key(pick_key());
      burst--;
    end
  endtask

  int phase_limit [7] = '{40, 100, 60, 180, 255, 224, 255};
  int phase_gap   [7] = '{6, 10, 0, 3, 8, 12, 4};

  initial begin
    start       <= 1'b0;
    key_i       <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    rst_ni      <= 1'b0;
    foreach (cluster_home[i]) cluster_home[i] = 8'($urandom);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: zero key, extremes, duplicates, displacement on one chain
    send_key('0);
    send_key('1);
    send_key(64'h1);
    send_key(64'h8000_0000_0000_0000);
    send_key('1);
    send_key(64'h0A31);
    send_key(64'h0A35);
    send_key(64'h0A3F);
    send_key(64'h0A33);
    send_key(64'h0A35);
    send_key('0);
    send_key('0);
    send_key(64'h5555_5555_5555_5555);
    send_key(64'hAAAA_AAAA_AAAA_AAAA);

    // Limit of zero: every new key is full, duplicates still found
    write_limit(8'd0);
    send_key(64'h1234_5678_9ABC_DEF0);
    send_key(64'h1);
    send_key('0);

    // Limit below the count: full, but a stored key is still a duplicate
    write_limit(8'd1);
    send_key(64'h0FED_CBA9_8765_4321);
    send_key(64'h0A33);
    send_key('1);

    // Random phases across a range of limits
    for (int p = 0; p < 7; p++) begin
      write_limit(8'(phase_limit[p]));
      run_items(PHASE_ITEMS, phase_gap[p]);
    end

    drain();
    repeat (32) @(posedge clk_i);
    if (sb.pending_outcomes.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.pending_outcomes.size());
      sb.errors++;
    end

    $display("ran %0d inserts over %0d limit settings, %0d results checked, %0d errors",
             keys_taken, limit_writes, sb.checked, sb.errors);
    $display("outcomes: new %0d, present %0d, full %0d, zero key %0d; final count %0d",
             sb.status_seen[STS_NEW], sb.status_seen[STS_DUP],
             sb.status_seen[STS_FULL], sb.status_seen[STS_ZERO], sb.key_count);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/ohsi_pkg.sv
sv/ohsi_ram.sv
sv/ohsi_ctrl.sv
sv/ohsi_dpath.sv
sv/ordered_hash_set_insert_top.sv
tb/sv/ordered_hash_set_insert_top_tb.sv
